// ===== hw/rtl/hpq_pkg.sv =====
// Shared types, constants and helpers for the heap priority queue.
package hpq_pkg;

  localparam int CAPACITY    = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int RES_W       = 32;
  localparam int OCC_W       = 11;

  // Heap levels: level L holds positions 2**L .. 2**(L+1)-1 (1-based)
  localparam int NLEV  = $clog2(CAPACITY + 1);
  localparam int POS_W = NLEV;
  localparam int LVL_W = $clog2(NLEV);
  localparam int IDX_W = NLEV - 1;
  localparam int ROW_W = (IDX_W > 1) ? IDX_W - 1 : 1;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [POS_W-1:0]              pos_t;
  typedef logic [LVL_W-1:0]              lvl_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [ROW_W-1:0]              row_t;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAST,
    S_ROOT,
    S_SIFT
  } state_t;

  // Word travelling down the chain of level cells
  typedef struct packed {
    logic valid;
    op_t  op;
    idx_t idx;
    val_t v;
  } tok_t;

  // Write handed back up to the parent level during a sift-down
  typedef struct packed {
    logic valid;
    idx_t idx;
    val_t value;
  } wb_t;

  // Direct read of one level, issued by the controller
  typedef struct packed {
    logic valid;
    lvl_t level;
    idx_t idx;
  } probe_t;

  // Per-level RAM request: both banks share the row
  typedef struct packed {
    logic re;
    logic we_l;
    logic we_r;
    row_t row;
    val_t wdata;
  } mem_req_t;

  // Operation context broadcast to every cell
  typedef struct packed {
    lvl_t tl;
    pos_t t;
    pos_t cnt;
  } ctx_t;

  function automatic lvl_t level_of(input pos_t p);
    lvl_t l;
    l = '0;
    for (int i = 0; i < POS_W; i++) begin
      if (p[i]) begin
        l = lvl_t'(i);
      end
    end
    return l;
  endfunction

  function automatic val_t ext_in(input logic signed [RES_W-1:0] x);
    return val_t'(x);
  endfunction

endpackage

// ===== hw/rtl/hpq_ram.sv =====
// Single-port RAM with registered read, one bank of one heap level.
module hpq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 2,
  parameter int ADDR_W = 1
) (
  input  logic              clk,
  input  logic              re,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr[IW-1:0]] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr[IW-1:0]];
    end
  end

endmodule

// ===== hw/rtl/hpq_cell.sv =====
// One heap level: read, compare and write of its nodes as a word passes through.
module hpq_cell (
  input  logic              clk,
  input  logic              rst,
  input  hpq_pkg::lvl_t     level,
  input  hpq_pkg::ctx_t     ctx,
  input  hpq_pkg::probe_t   probe,
  input  hpq_pkg::tok_t     tok_in,
  input  hpq_pkg::wb_t      wb_in,
  input  hpq_pkg::val_t     rd_l,
  input  hpq_pkg::val_t     rd_r,
  output hpq_pkg::tok_t     tok_out,
  output hpq_pkg::wb_t      wb_out,
  output hpq_pkg::mem_req_t mem,
  output logic              fin
);
  import hpq_pkg::*;

  tok_t tok;
  logic dec;
  pos_t base;
  pos_t left_pos;
  val_t node;
  val_t child;
  logic l_ok;
  logic r_ok;
  logic take_r;
  lvl_t bsel;
  logic path_bit;
  logic own_we;
  idx_t own_idx;
  val_t own_val;

  // A word first reads its row, then decides
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
      dec       <= 1'b0;
    end else if (tok_in.valid) begin
      tok <= tok_in;
      dec <= 1'b0;
    end else if (tok.valid && !dec) begin
      dec <= 1'b1;
    end else if (dec) begin
      tok.valid <= 1'b0;
      dec       <= 1'b0;
    end
  end

  always_comb begin
    base     = pos_t'(1) << level;
    left_pos = base + pos_t'(tok.idx);
    l_ok     = left_pos <= ctx.cnt;
    r_ok     = left_pos < ctx.cnt;
    // prefer the right child on a tie
    take_r   = r_ok && !(rd_l > rd_r);
    child    = take_r ? rd_r : rd_l;
    node     = tok.idx[0] ? rd_r : rd_l;
    bsel     = ctx.tl - level - lvl_t'(1);
    path_bit = ctx.t[bsel];

    tok_out = '0;
    wb_out  = '0;
    fin     = 1'b0;
    own_we  = 1'b0;
    own_idx = tok.idx;
    own_val = tok.v;

    if (tok.valid && dec) begin
      case (tok.op)
        OP_INSERT: begin
          own_we = 1'b1;
          if (level == ctx.tl) begin
            fin = 1'b1;
          end else begin
            // keep the larger here, carry the smaller down the path
            own_val       = (node > tok.v) ? node : tok.v;
            tok_out.valid = 1'b1;
            tok_out.op    = OP_INSERT;
            tok_out.idx   = (tok.idx << 1) | idx_t'(path_bit);
            tok_out.v     = (node > tok.v) ? tok.v : node;
          end
        end
        OP_EXTRACT: begin
          wb_out.valid = 1'b1;
          wb_out.idx   = tok.idx >> 1;
          if (l_ok && child > tok.v) begin
            wb_out.value  = child;
            tok_out.valid = 1'b1;
            tok_out.op    = OP_EXTRACT;
            tok_out.idx   = (tok.idx | idx_t'(take_r)) << 1;
            tok_out.v     = tok.v;
          end else begin
            wb_out.value = tok.v;
            fin          = 1'b1;
          end
        end
        default: begin
          fin = 1'b0;
        end
      endcase
    end

    mem = '0;
    if (tok.valid && !dec) begin
      mem.re  = 1'b1;
      mem.row = row_t'(tok.idx >> 1);
    end
    if (probe.valid && probe.level == level) begin
      mem.re  = 1'b1;
      mem.row = row_t'(probe.idx >> 1);
    end
    if (own_we) begin
      mem.we_l  = !own_idx[0];
      mem.we_r  = own_idx[0];
      mem.row   = row_t'(own_idx >> 1);
      mem.wdata = own_val;
    end else if (wb_in.valid) begin
      mem.we_l  = !wb_in.idx[0];
      mem.we_r  = wb_in.idx[0];
      mem.row   = row_t'(wb_in.idx >> 1);
      mem.wdata = wb_in.value;
    end
  end

endmodule

// ===== hw/rtl/max_heap_priority_queue.sv =====
// Top level: controller and the chain of heap level cells with their RAM banks.
// Binary max-heap priority queue of 1024 signed words, one level of the heap per
// cell, each level kept in two RAM banks (left and right siblings). Raise start
// with opcode and value while busy is low; the answer appears on result_value,
// status and occupancy for the single cycle in which done is high, and a new
// command may be started in that same cycle. The receiver cannot stall. An
// insert into a full heap or an extract from an empty one answers in the cycle
// after acceptance. Otherwise every level visited does a registered RAM read,
// then a compare and write, down to the level where an insert lands or where an
// extract's sift stops.
module max_heap_priority_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              opcode,
  input  logic signed [hpq_pkg::RES_W-1:0]  value,
  output logic                              busy,
  output logic                              done,
  output logic signed [hpq_pkg::RES_W-1:0]  result_value,
  output logic [1:0]                        status,
  output logic [hpq_pkg::OCC_W-1:0]         occupancy
);
  import hpq_pkg::*;

  state_t   state;
  state_t   state_next;
  pos_t     cnt;
  pos_t     cnt_next;
  pos_t     t;
  pos_t     t_next;
  lvl_t     tl;
  lvl_t     tl_next;
  logic     lane;
  logic     lane_next;
  val_t     v;
  val_t     v_next;
  val_t     res;
  val_t     res_next;
  status_t  st;
  status_t  st_next;
  logic     done_next;

  lvl_t     lvl_last;
  idx_t     idx_last;
  probe_t   probe;
  tok_t     launch;
  lvl_t     launch_lvl;
  ctx_t     ctx;

  tok_t     tok_i [NLEV];
  tok_t     tok_o [NLEV];
  wb_t      wb_i  [NLEV];
  wb_t      wb_o  [NLEV];
  mem_req_t req   [NLEV];
  val_t     rd_l  [NLEV];
  val_t     rd_r  [NLEV];
  logic [NLEV-1:0] fin;

  assign ctx = '{tl: tl, t: t, cnt: cnt};

  for (genvar L = 0; L < NLEV; L++) begin : g_lvl
    localparam int LSZ  = 1 << L;
    localparam int LCNT = (LSZ < CAPACITY - LSZ + 1) ? LSZ : CAPACITY - LSZ + 1;
    localparam int LDEP = (LCNT + 1) / 2;

    if (L == 0) begin : g_first
      assign tok_i[L] = (launch.valid && launch_lvl == lvl_t'(L)) ? launch : tok_t'('0);
    end else begin : g_next
      assign tok_i[L] = (launch.valid && launch_lvl == lvl_t'(L)) ? launch : tok_o[L-1];
    end

    if (L == NLEV - 1) begin : g_last
      assign wb_i[L] = wb_t'('0);
    end else begin : g_inner
      assign wb_i[L] = wb_o[L+1];
    end

    hpq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .level   (lvl_t'(L)),
      .ctx     (ctx),
      .probe   (probe),
      .tok_in  (tok_i[L]),
      .wb_in   (wb_i[L]),
      .rd_l    (rd_l[L]),
      .rd_r    (rd_r[L]),
      .tok_out (tok_o[L]),
      .wb_out  (wb_o[L]),
      .mem     (req[L]),
      .fin     (fin[L])
    );

    hpq_ram #(
      .WIDTH  (VALUE_WIDTH),
      .DEPTH  (LDEP),
      .ADDR_W (ROW_W)
    ) u_ram_l (
      .clk   (clk),
      .re    (req[L].re),
      .we    (req[L].we_l),
      .addr  (req[L].row),
      .wdata (req[L].wdata),
      .rdata (rd_l[L])
    );

    hpq_ram #(
      .WIDTH  (VALUE_WIDTH),
      .DEPTH  (LDEP),
      .ADDR_W (ROW_W)
    ) u_ram_r (
      .clk   (clk),
      .re    (req[L].re),
      .we    (req[L].we_r),
      .addr  (req[L].row),
      .wdata (req[L].wdata),
      .rdata (rd_r[L])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    t    <= t_next;
    tl   <= tl_next;
    lane <= lane_next;
    v    <= v_next;
    res  <= res_next;
    st   <= st_next;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    t_next     = t;
    tl_next    = tl;
    lane_next  = lane;
    v_next     = v;
    res_next   = res;
    st_next    = st;
    done_next  = 1'b0;
    probe      = '0;
    launch     = '0;
    launch_lvl = '0;
    lvl_last   = level_of(cnt);
    idx_last   = idx_t'(cnt - (pos_t'(1) << lvl_last));

    case (state)
      S_IDLE: begin
        if (start) begin
          if (opcode == OP_INSERT) begin
            if (cnt == pos_t'(CAPACITY)) begin
              done_next = 1'b1;
              st_next   = ST_FULL;
              res_next  = '0;
            end else begin
              // new element's path runs from the root to position cnt+1
              cnt_next     = cnt + pos_t'(1);
              t_next       = cnt + pos_t'(1);
              tl_next      = level_of(cnt + pos_t'(1));
              st_next      = ST_INSERTED;
              res_next     = '0;
              launch.valid = 1'b1;
              launch.op    = OP_INSERT;
              launch.v     = ext_in(value);
              launch_lvl   = '0;
              state_next   = S_SIFT;
            end
          end else begin
            if (cnt == '0) begin
              done_next = 1'b1;
              st_next   = ST_EMPTY;
              res_next  = '0;
            end else begin
              // fetch the last element first
              cnt_next    = cnt - pos_t'(1);
              tl_next     = lvl_last;
              lane_next   = idx_last[0];
              probe.valid = 1'b1;
              probe.level = lvl_last;
              probe.idx   = idx_last;
              state_next  = S_LAST;
            end
          end
        end
      end
      S_LAST: begin
        v_next      = lane ? rd_r[tl] : rd_l[tl];
        probe.valid = 1'b1;
        probe.level = '0;
        probe.idx   = '0;
        state_next  = S_ROOT;
      end
      S_ROOT: begin
        res_next = rd_l[0];
        st_next  = ST_EXTRACTED;
        if (cnt == '0) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          // sift the old last element down from the root; word enters at the children
          launch.valid = 1'b1;
          launch.op    = OP_EXTRACT;
          launch.idx   = '0;
          launch.v     = v;
          launch_lvl   = lvl_t'(1);
          state_next   = S_SIFT;
        end
      end
      S_SIFT: begin
        if (|fin) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy         = state != S_IDLE;
  assign result_value = RES_W'(res);
  assign status       = st;
  assign occupancy    = OCC_W'(cnt);

endmodule
